>>> rtl/sac_pkg.sv
package sac_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USE_LRU     = 2'd3;

    localparam logic [4:0] OFFSET_BITS_RST = 5'd6;
    localparam logic [3:0] SET_BITS_RST    = 4'd0;
    localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;
    localparam logic       USE_LRU_RST     = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAIN,
        ST_PREF,
        ST_NREAD,
        ST_NEXT
    } sac_state_t;

endpackage

>>> rtl/sac_tag_mem.sv
module sac_tag_mem
    import sac_pkg::*;
#(
    parameter int SETS  = 256,
    parameter int IDX_W = 8,
    parameter int ROW_W = 416
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [ROW_W-1:0] wr_data,
    output logic [ROW_W-1:0] rd_data,
    output logic             rd_ok
);

    logic [ROW_W-1:0] mem [SETS];
    logic [SETS-1:0]  ok_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // per-row written flags, an unwritten row reads as all invalid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg    <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                ok_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= ok_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_ok   = rd_ok_reg;

endmodule

>>> rtl/sac_set_unit.sv
module sac_set_unit
    import sac_pkg::*;
#(
    parameter int WAYS      = 8,
    parameter int ADDR_BITS = 48,
    parameter int RANK_W    = 3,
    parameter int WAY_W     = 3,
    parameter int CNT_W     = 4,
    parameter int ROW_W     = 416
)
(
    input  logic [ROW_W-1:0]     row_in,
    input  logic                 row_ok,
    input  logic [ADDR_BITS-1:0] key,
    input  logic                 promote_en,
    input  logic [CNT_W-1:0]     ways,
    output logic                 hit,
    output logic [ROW_W-1:0]     row_out
);

    localparam int RK_OFS = WAYS;
    localparam int TG_OFS = WAYS + WAYS * RANK_W;

    logic [WAYS-1:0]           v;
    logic [RANK_W-1:0]         rk [WAYS];
    logic [ADDR_BITS-1:0]      tg [WAYS];
    logic [WAYS-1:0]           v_new;
    logic [RANK_W-1:0]         rk_new [WAYS];
    logic [ADDR_BITS-1:0]      tg_new [WAYS];
    logic [WAY_W-1:0]          hit_way;
    logic [WAY_W-1:0]          oldest;
    logic [WAY_W-1:0]          slot;
    logic                      found;
    logic                      slot_found;
    logic [CNT_W-1:0]          count;
    logic [RANK_W-1:0]         hit_rank;
    logic [WAYS-1:0]           v_kept;

    always_comb
    begin
        hit        = 1'b0;
        hit_way    = '0;
        oldest     = '0;
        found      = 1'b0;
        count      = '0;
        slot       = '0;
        slot_found = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            v[w]  = row_ok & row_in[w];
            rk[w] = row_ok ? row_in[RK_OFS + w*RANK_W +: RANK_W] : '0;
            tg[w] = row_in[TG_OFS + w*ADDR_BITS +: ADDR_BITS];
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (v[w] && tg[w] == key)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        hit_rank = rk[hit_way];
        for (int w = 0; w < WAYS; w++)
        begin
            if (v[w])
            begin
                count = count + CNT_W'(1);
                if (!found || rk[w] > rk[oldest])
                begin
                    oldest = WAY_W'(w);
                    found  = 1'b1;
                end
            end
        end
        v_kept = v;
        if (found && count >= ways)
        begin
            v_kept[oldest] = 1'b0;
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!v_kept[w])
            begin
                slot       = WAY_W'(w);
                slot_found = 1'b1;
            end
        end
        v_new = v;
        for (int w = 0; w < WAYS; w++)
        begin
            rk_new[w] = rk[w];
            tg_new[w] = tg[w];
        end
        if (hit)
        begin
            if (promote_en)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (v[w] && rk[w] < hit_rank)
                    begin
                        rk_new[w] = rk[w] + RANK_W'(1);
                    end
                end
                rk_new[hit_way] = '0;
            end
        end
        else
        begin
            v_new = v_kept;
            for (int w = 0; w < WAYS; w++)
            begin
                if (v_kept[w])
                begin
                    rk_new[w] = rk[w] + RANK_W'(1);
                end
            end
            if (slot_found)
            begin
                v_new[slot]  = 1'b1;
                tg_new[slot] = key;
                rk_new[slot] = '0;
            end
        end
        row_out = '0;
        row_out[WAYS-1:0] = v_new;
        for (int w = 0; w < WAYS; w++)
        begin
            row_out[RK_OFS + w*RANK_W +: RANK_W]     = rk_new[w];
            row_out[TG_OFS + w*ADDR_BITS +: ADDR_BITS] = tg_new[w];
        end
    end

endmodule

>>> rtl/set_assoc_cache_with_prefetch.sv
// channel   direction  handshake              payload
// access    in         start & !busy          address, mode
// result    out        done, one cycle        plain_hit, plain_mem_reads, pref_hit,
//                                             pref_mem_reads, mem_write
// config    in         cfg_write              cfg_index, cfg_data
//
// one shared set-update unit serves the plain row, then the prefetch row
// and, on a prefetch miss, the next-line row, with a registered row read
// from each tag memory; the prefetch memory is read again for the next line.
// rst_n resets the config registers to their defaults and clears the sequencer
// and the row-written flags at once; no clearing pass. done cannot be held off.
module set_assoc_cache_with_prefetch
    import sac_pkg::*;
#(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_BITS-1:0]  address,
    input  logic                  mode,
    output logic                  done,
    output logic                  plain_hit,
    output logic                  plain_mem_reads,
    output logic                  pref_hit,
    output logic [1:0]            pref_mem_reads,
    output logic                  mem_write,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int IDX_W  = (SB_MAX > 0) ? SB_MAX : 1;
    localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W  = RANK_W;
    localparam int CNT_W  = $clog2(MAX_WAYS + 1);
    localparam int ROW_W  = MAX_WAYS * (1 + RANK_W + ADDR_BITS);

    sac_state_t state_reg, state_next;

    logic [4:0] offset_bits_reg;
    logic [3:0] set_bits_reg;
    logic [3:0] ways_in_use_reg;
    logic       use_lru_reg;

    logic [7:0]           b_eff, s_clip, s_eff;
    logic [CNT_W-1:0]     ways_eff;
    logic [IDX_W:0]       sets_mask;
    logic [ADDR_BITS-1:0] addr_b;
    logic [IDX_W-1:0]     set_idx;
    logic [ADDR_BITS-1:0] tag_in;
    logic [ADDR_BITS-1:0] tmask_in;
    logic                 accept;

    logic [IDX_W-1:0]     set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [ADDR_BITS-1:0] tmask_reg;
    logic                 last_reg;
    logic                 mode_reg;
    logic [IDX_W-1:0]     pset_reg;
    logic [ADDR_BITS-1:0] ptag_reg;

    logic       done_reg;
    logic       phit_reg;
    logic       qhit_reg;
    logic [1:0] qreads_reg;

    logic [ROW_W-1:0]     plain_rd, pref_rd, unit_row_in, unit_row_out;
    logic                 plain_ok, pref_ok, unit_ok;
    logic [ADDR_BITS-1:0] unit_key;
    logic                 unit_promote, unit_hit;
    logic                 pref_rd_en, pref_wr_en;
    logic [IDX_W-1:0]     pref_rd_addr, pref_wr_addr;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        b_eff = ({3'd0, offset_bits_reg} > 8'(ADDR_BITS)) ? 8'(ADDR_BITS)
                                                           : {3'd0, offset_bits_reg};
        s_clip = ({4'd0, set_bits_reg} > 8'(SB_MAX)) ? 8'(SB_MAX) : {4'd0, set_bits_reg};
        s_eff  = (s_clip > 8'(ADDR_BITS) - b_eff) ? 8'(ADDR_BITS) - b_eff : s_clip;
        if (ways_in_use_reg == 4'd0)
        begin
            ways_eff = CNT_W'(1);
        end
        else if ({4'd0, ways_in_use_reg} > 8'(MAX_WAYS))
        begin
            ways_eff = CNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = CNT_W'(ways_in_use_reg);
        end
        sets_mask = ((IDX_W+1)'(1) << s_eff) - (IDX_W+1)'(1);
        addr_b    = address >> b_eff;
        set_idx   = addr_b[IDX_W-1:0] & sets_mask[IDX_W-1:0];
        tag_in    = address >> (b_eff + s_eff);
        tmask_in  = ~({ADDR_BITS{1'b1}} << (8'(ADDR_BITS) - b_eff - s_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RST;
            set_bits_reg    <= SET_BITS_RST;
            ways_in_use_reg <= WAYS_IN_USE_RST;
            use_lru_reg     <= USE_LRU_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_OFFSET_BITS: offset_bits_reg <= cfg_data[4:0];
                REG_SET_BITS:    set_bits_reg    <= cfg_data[3:0];
                REG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[3:0];
                REG_USE_LRU:     use_lru_reg     <= cfg_data[0];
                default:         use_lru_reg     <= use_lru_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg   <= set_idx;
            tag_reg   <= tag_in;
            tmask_reg <= tmask_in;
            last_reg  <= (set_idx == sets_mask[IDX_W-1:0]);
            mode_reg  <= mode;
        end
        if (state_reg == ST_PREF)
        begin
            pset_reg <= last_reg ? '0 : set_reg + IDX_W'(1);
            ptag_reg <= last_reg ? ((tag_reg + ADDR_BITS'(1)) & tmask_reg) : tag_reg;
        end
        if (state_reg == ST_PLAIN)
        begin
            phit_reg <= unit_hit;
        end
        if (state_reg == ST_PREF)
        begin
            qhit_reg   <= unit_hit;
            qreads_reg <= unit_hit ? 2'd0 : 2'd1;
        end
        if (state_reg == ST_NEXT)
        begin
            qreads_reg <= unit_hit ? 2'd1 : 2'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_PREF && unit_hit) || (state_reg == ST_NEXT);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = accept ? ST_PLAIN : ST_IDLE;
            ST_PLAIN: state_next = ST_PREF;
            ST_PREF:  state_next = unit_hit ? ST_IDLE : ST_NREAD;
            ST_NREAD: state_next = ST_NEXT;
            ST_NEXT:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign unit_row_in  = (state_reg == ST_PLAIN) ? plain_rd : pref_rd;
    assign unit_ok      = (state_reg == ST_PLAIN) ? plain_ok : pref_ok;
    assign unit_key     = (state_reg == ST_NEXT) ? ptag_reg : tag_reg;
    assign unit_promote = use_lru_reg && (state_reg != ST_NEXT);

    assign pref_rd_en   = accept || (state_reg == ST_NREAD);
    assign pref_rd_addr = (state_reg == ST_NREAD) ? pset_reg : set_idx;
    assign pref_wr_en   = (state_reg == ST_PREF) || (state_reg == ST_NEXT);
    assign pref_wr_addr = (state_reg == ST_NEXT) ? pset_reg : set_reg;

    sac_set_unit #(
        .WAYS      (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS),
        .RANK_W    (RANK_W),
        .WAY_W     (WAY_W),
        .CNT_W     (CNT_W),
        .ROW_W     (ROW_W)
    ) u_unit (
        .row_in     (unit_row_in),
        .row_ok     (unit_ok),
        .key        (unit_key),
        .promote_en (unit_promote),
        .ways       (ways_eff),
        .hit        (unit_hit),
        .row_out    (unit_row_out)
    );

    sac_tag_mem #(
        .SETS  (MAX_SETS),
        .IDX_W (IDX_W),
        .ROW_W (ROW_W)
    ) u_plain_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (set_idx),
        .wr_en   (state_reg == ST_PLAIN),
        .wr_addr (set_reg),
        .wr_data (unit_row_out),
        .rd_data (plain_rd),
        .rd_ok   (plain_ok)
    );

    sac_tag_mem #(
        .SETS  (MAX_SETS),
        .IDX_W (IDX_W),
        .ROW_W (ROW_W)
    ) u_pref_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (pref_rd_en),
        .rd_addr (pref_rd_addr),
        .wr_en   (pref_wr_en),
        .wr_addr (pref_wr_addr),
        .wr_data (unit_row_out),
        .rd_data (pref_rd),
        .rd_ok   (pref_ok)
    );

    assign done            = done_reg;
    assign plain_hit       = phit_reg;
    assign plain_mem_reads = !phit_reg;
    assign pref_hit        = qhit_reg;
    assign pref_mem_reads  = qreads_reg;
    assign mem_write       = mode_reg;

endmodule

>>> verif/set_assoc_cache_with_prefetch_test.sv
module set_assoc_cache_with_prefetch_test
    import sac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSETS = 256;
    localparam int NWAYS = 8;
    localparam int ABITS = 48;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       plain_hit;
        logic       plain_mem_reads;
        logic       pref_hit;
        logic [1:0] pref_mem_reads;
        logic       mem_write;
    } access_outcome_t;

    class cache_scoreboard;
        logic [ABITS-1:0] tags [2][NSETS][NWAYS];
        bit               valid [2][NSETS][NWAYS];
        int               rank [2][NSETS][NWAYS];
        logic [4:0]       offset_reg;
        logic [3:0]       set_reg;
        logic [3:0]       ways_reg;
        logic             lru_reg;
        access_outcome_t  pending [$];
        int               errors;

        function new();
            offset_reg = OFFSET_BITS_RST;
            set_reg = SET_BITS_RST;
            ways_reg = WAYS_IN_USE_RST;
            lru_reg = USE_LRU_RST;
            errors = 0;
            for (int c = 0; c < 2; c++)
                for (int s = 0; s < NSETS; s++)
                    for (int w = 0; w < NWAYS; w++)
                    begin
                        valid[c][s][w] = 0;
                        rank[c][s][w] = 0;
                        tags[c][s][w] = '0;
                    end
        endfunction

        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_OFFSET_BITS: offset_reg = data[4:0];
                REG_SET_BITS:    set_reg = data[3:0];
                REG_WAYS_IN_USE: ways_reg = data[3:0];
                REG_USE_LRU:     lru_reg = data[0];
                default: ;
            endcase
        endfunction

        function int lookup(int c, int s, logic [ABITS-1:0] tag);
            for (int w = 0; w < NWAYS; w++)
                if (valid[c][s][w] && tags[c][s][w] == tag)
                    return w;
            return -1;
        endfunction

        function void promote(int c, int s, int way);
            int r;
            r = rank[c][s][way];
            for (int w = 0; w < NWAYS; w++)
                if (valid[c][s][w] && rank[c][s][w] < r)
                    rank[c][s][w]++;
            rank[c][s][way] = 0;
        endfunction

        function void fill(int c, int s, logic [ABITS-1:0] tag, int ways);
            int slot;
            int oldest;
            int count;
            slot = -1;
            oldest = -1;
            count = 0;
            for (int w = 0; w < NWAYS; w++)
                if (valid[c][s][w])
                begin
                    count++;
                    if (oldest < 0 || rank[c][s][w] > rank[c][s][oldest])
                        oldest = w;
                end
            if (count >= ways && oldest >= 0)
                valid[c][s][oldest] = 0;
            for (int w = 0; w < NWAYS; w++)
                if (!valid[c][s][w])
                begin
                    if (slot < 0)
                        slot = w;
                end
                else
                    rank[c][s][w]++;
            if (slot >= 0)
            begin
                valid[c][s][slot] = 1;
                tags[c][s][slot] = tag;
                rank[c][s][slot] = 0;
            end
        endfunction

        function void note_access(logic [ABITS-1:0] addr, logic wr);
            int b;
            int s;
            int ways;
            int nsets;
            int tbits;
            int set_idx;
            int w;
            logic [63:0] tag;
            logic [63:0] next_tag;
            access_outcome_t exp_out;
            b = offset_reg;
            s = set_reg;
            ways = ways_reg;
            if (b > ABITS) b = ABITS;
            if (s > 8) s = 8;
            if (s > ABITS - b) s = ABITS - b;
            if (ways < 1) ways = 1;
            if (ways > NWAYS) ways = NWAYS;
            nsets = 1 << s;
            tbits = ABITS - b - s;
            set_idx = int'((64'(addr) >> b) & 64'(nsets - 1));
            tag = 64'(addr) >> (b + s);
            exp_out = '0;
            exp_out.mem_write = wr;

            w = lookup(0, set_idx, tag[ABITS-1:0]);
            if (w >= 0)
            begin
                exp_out.plain_hit = 1;
                if (lru_reg) promote(0, set_idx, w);
            end
            else
            begin
                exp_out.plain_mem_reads = 1;
                fill(0, set_idx, tag[ABITS-1:0], ways);
            end

            w = lookup(1, set_idx, tag[ABITS-1:0]);
            if (w >= 0)
            begin
                exp_out.pref_hit = 1;
                if (lru_reg) promote(1, set_idx, w);
            end
            else
            begin
                fill(1, set_idx, tag[ABITS-1:0], ways);
                exp_out.pref_mem_reads = 2'd1;
                if (set_idx + 1 < nsets)
                begin
                    if (lookup(1, set_idx + 1, tag[ABITS-1:0]) < 0)
                    begin
                        fill(1, set_idx + 1, tag[ABITS-1:0], ways);
                        exp_out.pref_mem_reads = 2'd2;
                    end
                end
                else
                begin
                    next_tag = (tag + 64'd1) & ((64'd1 << tbits) - 64'd1);
                    if (lookup(1, 0, next_tag[ABITS-1:0]) < 0)
                    begin
                        fill(1, 0, next_tag[ABITS-1:0], ways);
                        exp_out.pref_mem_reads = 2'd2;
                    end
                end
            end
            pending.push_back(exp_out);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(access_outcome_t got);
            access_outcome_t want;
            if (pending.size() == 0)
            begin
                report("result with no access outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.plain_hit !== want.plain_hit)
                report($sformatf("plain_hit %b want %b", got.plain_hit, want.plain_hit));
            if (got.plain_mem_reads !== want.plain_mem_reads)
                report($sformatf("plain_mem_reads %b want %b",
                                 got.plain_mem_reads, want.plain_mem_reads));
            if (got.pref_hit !== want.pref_hit)
                report($sformatf("pref_hit %b want %b", got.pref_hit, want.pref_hit));
            if (got.pref_mem_reads !== want.pref_mem_reads)
                report($sformatf("pref_mem_reads %0d want %0d",
                                 got.pref_mem_reads, want.pref_mem_reads));
            if (got.mem_write !== want.mem_write)
                report($sformatf("mem_write %b want %b", got.mem_write, want.mem_write));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [ABITS-1:0]      address;
    logic                  mode;
    logic                  done;
    logic                  plain_hit;
    logic                  plain_mem_reads;
    logic                  pref_hit;
    logic [1:0]            pref_mem_reads;
    logic                  mem_write;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cache_scoreboard sb;
    int              cycles;
    bit              idling_on;
    logic [ABITS-1:0] region_base;
    int              region_shift;

    set_assoc_cache_with_prefetch dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result({plain_hit, plain_mem_reads, pref_hit, pref_mem_reads, mem_write});

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.note_register(idx, data);
        cfg_write <= 0;
        @(posedge clk);
    endtask

    // wait for every outstanding result, then let the block settle
    task drain();
        start <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task configure(int off, int sets, int ways, int lru);
        drain();
        write_reg(REG_OFFSET_BITS, CFG_DATA_W'(off));
        write_reg(REG_SET_BITS, CFG_DATA_W'(sets));
        write_reg(REG_WAYS_IN_USE, CFG_DATA_W'(ways));
        write_reg(REG_USE_LRU, CFG_DATA_W'(lru));
        region_shift = off > ABITS ? ABITS : off;
        region_base = ABITS'({$urandom, $urandom});
    endtask

    task send_access(logic [ABITS-1:0] addr, logic wr);
        int gap;
        if (idling_on && $urandom_range(99) < 19)
        begin
            start <= 0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        address <= addr;
        mode <= wr;
        do
            @(posedge clk);
        while (busy);
        sb.note_access(addr, wr);
    endtask

    // mostly blocks near a per-phase base so sets fill up and hit
    function logic [ABITS-1:0] pick_address();
        logic [ABITS-1:0] a;
        if ($urandom_range(99) < 20)
            return ABITS'({$urandom, $urandom});
        a = region_base + (ABITS'($urandom_range(0, 40)) << region_shift);
        if ($urandom_range(3) == 0)
            a = a + (ABITS'($urandom_range(0, 3)) << (region_shift + 8));
        return a;
    endfunction

    initial
    begin
        sb = new();
        rst_n = 0;
        start = 0;
        address = '0;
        mode = 0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        idling_on = 1;
        region_shift = 6;
        region_base = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset configuration, tag overflow from a single set
        send_access('0, 0);
        send_access('0, 1);
        send_access('1, 0);
        send_access('0, 1);
        send_access(48'h40, 0);

        configure(0, 8, 8, 1);
        send_access(48'hff, 0);
        send_access(48'hff, 1);
        send_access(48'hfe, 0);
        send_access('1, 0);
        send_access(48'hff, 0);
        send_access(48'h1ff, 1);

        // saturated offset, set and way fields
        configure(31, 15, 15, 0);
        send_access('1, 1);
        send_access(48'h7fff_ffff_ffff, 0);
        send_access('1, 0);
        send_access('0, 0);

        configure(16, 8, 0, 1);
        send_access(48'h00ff_ffff, 0);
        send_access(48'h00ff_0000, 1);
        send_access('0, 0);

        // shrink the ways under lines already stored
        configure(16, 8, 8, 1);
        for (int i = 0; i < 4; i++)
            send_access(ABITS'(i) << 24, i[0]);
        drain();
        write_reg(REG_WAYS_IN_USE, CFG_DATA_W'(2));
        send_access(48'h5 << 24, 0);
        send_access(48'h1 << 24, 1);

        for (int ph = 0; ph < 13; ph++)
        begin
            case (ph)
                0: configure(0, 0, 1, 0);
                1: configure(16, 8, 8, 1);
                2: configure(6, 2, 4, 1);
                3: configure(4, 3, 2, 0);
                default: configure($urandom_range(0, 31) > 20 ? $urandom_range(0, 31)
                                                               : $urandom_range(0, 12),
                                   $urandom_range(0, 15), $urandom_range(0, 15),
                                   $urandom_range(0, 1));
            endcase
            idling_on = (ph != 5);
            for (int i = 0; i < 100; i++)
            begin
                if (ph == 7 && i == 50)
                    drain();
                if (ph > 8 && i == 50)
                begin
                    drain();
                    write_reg(REG_WAYS_IN_USE, CFG_DATA_W'($urandom_range(0, 15)));
                end
                send_access(pick_address(), 1'($urandom_range(0, 1)));
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> set_assoc_cache_with_prefetch.f
rtl/sac_pkg.sv
rtl/sac_tag_mem.sv
rtl/sac_set_unit.sv
rtl/set_assoc_cache_with_prefetch.sv
verif/set_assoc_cache_with_prefetch_test.sv
